[rtl/pem_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the prewitt edge magnitude unit
// no dependencies

package pem_pkg;

	localparam int CFG_BITS       = 11;
	localparam int CFG_INDEX_BITS = 2;
	localparam int OUT_BITS       = 11;
	localparam int M_TDATA_BITS   = 40;
	localparam int MIN_SIZE       = 3;

	localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(1024);

	localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_WIDTH   = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = CFG_INDEX_BITS'(1);

	typedef struct packed {
		logic valid;
		logic last;
	} pem_tag_t;

endpackage

[rtl/prewitt_edge_magnitude_unit.sv]
`timescale 1ns / 1ps
// top level of the prewitt edge magnitude unit
// depends on pem_pkg, pem_line_store, pem_window, pem_isqrt_cell

// Takes one pixel per clock cycle in raster order and gives, for every interior
// pixel, the horizontal and vertical Prewitt gradients and the floor square root
// of their sum of squares; border positions give no beat. The line store has a
// single read port and is read once per pixel, which sets the rate at one pixel
// per cycle whenever the output side takes its beats. After the pixel that
// completes its window is taken, a result passes through line store read, window,
// gradients, squares, sum, then one square root cell per root bit (GW cells, GW =
// PIXEL_BITS + 3). A write to the line width or frame height register restarts the
// frame at row 0, column 0; stored lines are kept. The line store needs no clearing.
// m_tlast marks the last interior result of a frame.

module prewitt_edge_magnitude_unit import pem_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [CFG_INDEX_BITS-1:0]           cfg_index,
	input  logic [CFG_BITS-1:0]                 cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((PIXEL_BITS+7)/8)*8-1:0]     s_tdata,   // pixel_value
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [M_TDATA_BITS-1:0]             m_tdata,   // horizontal_gradient,
	                                                       // vertical_gradient,
	                                                       // edge_magnitude
	output logic                                m_tlast
);

	localparam int GW = PIXEL_BITS + 3;
	localparam int XW = 2 * GW - 1;
	localparam int PW = 2 * GW;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1) + CFG_BITS;
	localparam int HW = $clog2(MAX_HEIGHT + 1) + CFG_BITS;

	logic [CFG_BITS-1:0]   width_q;
	logic [CFG_BITS-1:0]   height_q;
	logic [CW-1:0]         col_q;
	logic [RW-1:0]         row_q;
	logic [WW-1:0]         eff_w;
	logic [HW-1:0]         eff_h;
	logic [WW-1:0]         width_ext;
	logic [HW-1:0]         height_ext;
	logic                  last_col;
	logic                  last_row;
	logic                  adv;
	logic                  accept;
	logic                  cfg_hit;
	logic [PIXEL_BITS-1:0] pix;

	pem_tag_t              tag_s1;
	logic                  emit_s1;
	logic [CW-1:0]         col_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [2*PIXEL_BITS-1:0] rd_data;
	logic [PIXEL_BITS-1:0] top_rd;
	logic [PIXEL_BITS-1:0] mid_rd;
	pem_tag_t              win_tag_in;

	pem_tag_t              tag_s3;
	logic signed [GW-1:0]  gh_s3;
	logic signed [GW-1:0]  gv_s3;
	logic signed [2*GW-1:0] sq_h;
	logic signed [2*GW-1:0] sq_v;

	pem_tag_t              tag_s4;
	logic [XW-1:0]         sqh_s4;
	logic [XW-1:0]         sqv_s4;
	logic [PW-1:0]         pay_s4;

	pem_tag_t              tag_s5;
	logic [XW-1:0]         sum_s5;
	logic [PW-1:0]         pay_s5;

	pem_tag_t              tag_c  [GW+1];
	logic [XW-1:0]         x_c    [GW+1];
	logic [XW-1:0]         root_c [GW+1];
	logic [PW-1:0]         pay_c  [GW+1];

	logic signed [GW-1:0]  gh_out;
	logic signed [GW-1:0]  gv_out;
	logic [GW-1:0]         mag_out;
	logic [OUT_BITS-1:0]   gh_f;
	logic [OUT_BITS-1:0]   gv_f;
	logic [OUT_BITS-1:0]   mag_f;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign accept   = s_tvalid && adv;
	assign pix      = s_tdata[PIXEL_BITS-1:0];
	assign cfg_hit  = cfg_we && (cfg_index == REG_LINE_WIDTH || cfg_index == REG_FRAME_HEIGHT);

	// clamp of the frame size registers
	always_comb begin
		width_ext  = WW'(width_q);
		height_ext = HW'(height_q);
		if (width_ext < WW'(MIN_SIZE)) begin
			eff_w = WW'(MIN_SIZE);
		end else if (width_ext > WW'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = width_ext;
		end
		if (height_ext < HW'(MIN_SIZE)) begin
			eff_h = HW'(MIN_SIZE);
		end else if (height_ext > HW'(MAX_HEIGHT)) begin
			eff_h = HW'(MAX_HEIGHT);
		end else begin
			eff_h = height_ext;
		end
	end

	assign last_col = WW'(col_q) + WW'(1) >= eff_w;
	assign last_row = HW'(row_q) + HW'(1) >= eff_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_RESET;
			height_q <= CFG_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_LINE_WIDTH) begin
				width_q <= cfg_data;
			end
			if (cfg_index == REG_FRAME_HEIGHT) begin
				height_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// stage 1: line store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (adv) begin
			tag_s1.valid <= accept;
			tag_s1.last  <= last_col && last_row;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1 <= (row_q >= RW'(2)) && (col_q >= CW'(2));
			col_s1  <= col_q;
			pix_s1  <= pix;
		end
	end

	// store word: upper row in the low half, middle row in the high half
	pem_line_store #(
		.DEPTH (MAX_WIDTH),
		.DW    (2 * PIXEL_BITS)
	) u_line_store (
		.clk   (clk),
		.we    (tag_s1.valid && adv),
		.waddr (col_s1),
		.wdata ({pix_s1, mid_rd}),
		.re    (accept),
		.raddr (col_q),
		.rdata (rd_data)
	);

	assign top_rd = rd_data[PIXEL_BITS-1:0];
	assign mid_rd = rd_data[2*PIXEL_BITS-1:PIXEL_BITS];

	assign win_tag_in.valid = tag_s1.valid && emit_s1;
	assign win_tag_in.last  = tag_s1.last;

	pem_window #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.shift   (tag_s1.valid && adv),
		.tag_in  (win_tag_in),
		.top     (top_rd),
		.mid     (mid_rd),
		.pix     (pix_s1),
		.tag_out (tag_s3),
		.gh      (gh_s3),
		.gv      (gv_s3)
	);

	// stage 4: squares, stage 5: sum
	assign sq_h = gh_s3 * gh_s3;
	assign sq_v = gv_s3 * gv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s4 <= '0;
			tag_s5 <= '0;
		end else if (adv) begin
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqh_s4 <= sq_h[XW-1:0];
			sqv_s4 <= sq_v[XW-1:0];
			pay_s4 <= {gv_s3, gh_s3};
			sum_s5 <= sqh_s4 + sqv_s4;
			pay_s5 <= pay_s4;
		end
	end

	assign tag_c[0]  = tag_s5;
	assign x_c[0]    = sum_s5;
	assign root_c[0] = '0;
	assign pay_c[0]  = pay_s5;

	for (genvar k = 0; k < GW; k++) begin : g_cell
		pem_isqrt_cell #(
			.XW   (XW),
			.STEP (GW - 1 - k),
			.PW   (PW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.tag_in   (tag_c[k]),
			.x_in     (x_c[k]),
			.root_in  (root_c[k]),
			.pay_in   (pay_c[k]),
			.tag_out  (tag_c[k+1]),
			.x_out    (x_c[k+1]),
			.root_out (root_c[k+1]),
			.pay_out  (pay_c[k+1])
		);
	end

	assign gh_out  = $signed(pay_c[GW][GW-1:0]);
	assign gv_out  = $signed(pay_c[GW][2*GW-1:GW]);
	assign mag_out = root_c[GW][GW-1:0];
	assign gh_f    = OUT_BITS'(gh_out);
	assign gv_f    = OUT_BITS'(gv_out);
	assign mag_f   = OUT_BITS'(mag_out);

	assign m_tvalid = tag_c[GW].valid;
	assign m_tlast  = tag_c[GW].last;
	assign m_tdata  = M_TDATA_BITS'({mag_f, gv_f, gh_f});

	// position counters stay inside the frame in use
	assert property (@(posedge clk) disable iff (!arst_n)
		(WW'(col_q) < eff_w) && (HW'(row_q) < eff_h))
		else $error("pixel position outside frame");

	// the last pixel of a frame returns both counters to the origin
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_col && last_row && !cfg_we) |=> (col_q == '0 && row_q == '0))
		else $error("frame did not wrap");

endmodule

[rtl/pem_line_store.sv]
`timescale 1ns / 1ps
// two-row line store: one write port, one read port with registered data
// no dependencies

module pem_line_store #(
	parameter int DEPTH = 1024,
	parameter int DW    = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/pem_window.sv]
`timescale 1ns / 1ps
// 3x3 window of column cells and the prewitt gradient stage
// depends on pem_pkg

module pem_window import pem_pkg::*; #(
	parameter int PIXEL_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  logic                           shift,
	input  pem_tag_t                       tag_in,
	input  logic [PIXEL_BITS-1:0]          top,
	input  logic [PIXEL_BITS-1:0]          mid,
	input  logic [PIXEL_BITS-1:0]          pix,
	output pem_tag_t                       tag_out,
	output logic signed [PIXEL_BITS+2:0]   gh,
	output logic signed [PIXEL_BITS+2:0]   gv
);

	localparam int GW = PIXEL_BITS + 3;

	logic [PIXEL_BITS-1:0] win_q [3][3];
	pem_tag_t              tag_s2;
	pem_tag_t              tag_s3;
	logic signed [GW-1:0]  gh_s3;
	logic signed [GW-1:0]  gv_s3;
	logic [GW-1:0]         left_sum;
	logic [GW-1:0]         right_sum;
	logic [GW-1:0]         upper_sum;
	logic [GW-1:0]         lower_sum;

	// columns move left, the new column enters on the right
	always_ff @(posedge clk) begin
		if (shift) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= top;
			win_q[1][2] <= mid;
			win_q[2][2] <= pix;
		end
	end

	always_comb begin
		left_sum  = GW'(win_q[0][0]) + GW'(win_q[1][0]) + GW'(win_q[2][0]);
		right_sum = GW'(win_q[0][2]) + GW'(win_q[1][2]) + GW'(win_q[2][2]);
		upper_sum = GW'(win_q[0][0]) + GW'(win_q[0][1]) + GW'(win_q[0][2]);
		lower_sum = GW'(win_q[2][0]) + GW'(win_q[2][1]) + GW'(win_q[2][2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (adv) begin
			tag_s2 <= tag_in;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gh_s3 <= $signed(right_sum - left_sum);
			gv_s3 <= $signed(upper_sum - lower_sum);
		end
	end

	assign tag_out = tag_s3;
	assign gh      = gh_s3;
	assign gv      = gv_s3;

endmodule

[rtl/pem_isqrt_cell.sv]
`timescale 1ns / 1ps
// one cell of the square root chain: settles one root bit per beat
// depends on pem_pkg

module pem_isqrt_cell import pem_pkg::*; #(
	parameter int XW   = 21,
	parameter int STEP = 0,
	parameter int PW   = 22
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  pem_tag_t      tag_in,
	input  logic [XW-1:0] x_in,
	input  logic [XW-1:0] root_in,
	input  logic [PW-1:0] pay_in,
	output pem_tag_t      tag_out,
	output logic [XW-1:0] x_out,
	output logic [XW-1:0] root_out,
	output logic [PW-1:0] pay_out
);

	localparam logic [XW:0] BIT = (XW+1)'(1) << (2 * STEP);

	pem_tag_t      tag_q;
	logic [XW-1:0] x_q;
	logic [XW-1:0] root_q;
	logic [PW-1:0] pay_q;
	logic [XW:0]   trial;
	logic          fits;

	assign trial = {1'b0, root_in} + BIT;
	assign fits  = {1'b0, x_in} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else if (adv) begin
			tag_q <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_q <= pay_in;
			if (fits) begin
				x_q    <= x_in - trial[XW-1:0];
				root_q <= (root_in >> 1) + BIT[XW-1:0];
			end else begin
				x_q    <= x_in;
				root_q <= root_in >> 1;
			end
		end
	end

	assign tag_out  = tag_q;
	assign x_out    = x_q;
	assign root_out = root_q;
	assign pay_out  = pay_q;

endmodule
